@@ hdl/pexe_pkg.sv @@
// Shared types and constants for the prefix expression evaluator.
// No dependencies; imported by every module of the block.
package pexe_pkg;

	localparam int DEF_STACK_DEPTH = 128;
	localparam int DEF_QUEUE_DEPTH = 4;
	localparam int WORD_W = 32;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_STAR  = 8'h2A;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;

	localparam logic [WORD_W-1:0] EMPTY_VALUE = '1;

	typedef struct packed {
		logic [7:0] symbol;
		logic       final_req;
	} item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] answer;
		logic                     underflow;
		logic                     overflow;
		logic                     divide_by_zero;
	} result_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_DIGIT,
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] digit;
		logic       final_req;
	} cmd_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP_A,
		ST_POP_B,
		ST_EXEC,
		ST_DIV,
		ST_PUSH,
		ST_FIN,
		ST_EMIT
	} exec_state_t;

endpackage

@@ hdl/pexe_front.sv @@
// Front end: input register and character classification.
// Depends on pexe_pkg; feeds pexe_queue.
module pexe_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  pexe_pkg::item_t item,
	input  logic           q_full,
	output logic           q_push,
	output pexe_pkg::cmd_t q_cmd
);
	import pexe_pkg::*;

	logic       valid_s1;
	cmd_t       cmd_s1;
	cmd_t       cmd_new;
	logic [7:0] sym_off;
	logic       drop;
	logic       advance;

	always_comb begin
		sym_off = item.symbol - CHAR_ZERO;
		cmd_new.digit = sym_off[3:0];
		cmd_new.final_req = item.final_req;
		case (item.symbol) inside
			[CHAR_ZERO:CHAR_NINE]: cmd_new.op = OP_DIGIT;
			CHAR_PLUS:             cmd_new.op = OP_ADD;
			CHAR_MINUS:            cmd_new.op = OP_SUB;
			CHAR_STAR:             cmd_new.op = OP_MUL;
			CHAR_SLASH:            cmd_new.op = OP_DIV;
			default:               cmd_new.op = OP_NONE;
		endcase
	end

	// ignored characters that do not end an expression never reach the queue
	assign drop = (cmd_s1.op == OP_NONE) && !cmd_s1.final_req;
	assign advance = valid_s1 && (drop || !q_full);
	assign item_stall = valid_s1 && !advance;
	assign q_push = valid_s1 && !drop && !q_full;
	assign q_cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			cmd_s1 <= cmd_new;
		end
	end

endmodule

@@ hdl/pexe_queue.sv @@
// Command queue between front end and execution unit.
// Depends on pexe_pkg.
module pexe_queue #(
	parameter int DEPTH = pexe_pkg::DEF_QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pexe_pkg::cmd_t cmd_in,
	output logic           full,
	output logic           valid,
	output pexe_pkg::cmd_t cmd_out,
	input  logic           pop
);
	import pexe_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cmd_t          entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full = (cnt_q == FULL_CNT);
	assign valid = (cnt_q != '0);
	assign cmd_out = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

@@ hdl/pexe_div.sv @@
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
// Depends on pexe_pkg; the divisor must be nonzero at start.
module pexe_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [pexe_pkg::WORD_W-1:0]    dividend,
	input  logic [pexe_pkg::WORD_W-1:0]    divisor,
	output pexe_pkg::div_rsp_t             rsp
);
	import pexe_pkg::*;

	localparam int SW = $clog2(WORD_W);
	localparam logic [SW-1:0] LAST_STEP = SW'(WORD_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [SW-1:0]     step_q;
	logic              neg_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] quo_q;
	logic [WORD_W-1:0] dvs_q;
	logic [WORD_W:0]   shifted;
	logic [WORD_W:0]   diff;

	assign shifted = {rem_q, quo_q[WORD_W-1]};
	assign diff = shifted - {1'b0, dvs_q};

	assign rsp.done = done_q;
	assign rsp.quotient = neg_q ? (WORD_W'(0) - quo_q) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + SW'(1);
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
			quo_q <= dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
			dvs_q <= divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[WORD_W]) begin
				rem_q <= diff[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b0};
			end
		end
	end

endmodule

@@ hdl/pexe_exec.sv @@
// Execution unit: operand stack memory, sequencer, ALU and result register.
// Depends on pexe_pkg and pexe_div.
module pexe_exec #(
	parameter int STACK_DEPTH = pexe_pkg::DEF_STACK_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  pexe_pkg::cmd_t    cmd,
	output logic              cmd_pop,
	output logic              result_valid,
	input  logic              result_stall,
	output pexe_pkg::result_t result
);
	import pexe_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);

	logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
	logic [WORD_W-1:0] rd_data_q;

	exec_state_t       state_q, state_d;
	logic [CW-1:0]     count_q, count_d;
	logic              hit_q, hit_d;
	logic              unf_q, unf_d;
	logic              ovf_q, ovf_d;
	logic              dz_q, dz_d;
	logic              out_valid_q, out_valid_d;
	op_t               op_q, op_d;
	logic              final_q, final_d;
	logic [WORD_W-1:0] a_q, a_d;
	logic [WORD_W-1:0] b_q, b_d;
	logic [WORD_W-1:0] res_q, res_d;
	result_t           out_q, out_d;

	logic              wr_en;
	logic [WORD_W-1:0] wr_data;
	logic [CW-1:0]     top_cnt;
	logic              div_start;
	div_rsp_t          div_rsp;

	assign top_cnt = count_q - CW'(1);
	assign result_valid = out_valid_q;
	assign result = out_q;

	pexe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (a_q),
		.divisor  (b_q),
		.rsp      (div_rsp)
	);

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		hit_d = hit_q;
		unf_d = unf_q;
		ovf_d = ovf_q;
		dz_d = dz_q;
		op_d = op_q;
		final_d = final_q;
		a_d = a_q;
		b_d = b_q;
		res_d = res_q;
		out_d = out_q;
		out_valid_d = out_valid_q && result_stall;
		wr_en = 1'b0;
		wr_data = res_q;
		cmd_pop = 1'b0;
		div_start = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					op_d = cmd.op;
					final_d = cmd.final_req;
					state_d = cmd.final_req ? ST_FIN : ST_IDLE;
					case (cmd.op) inside
						OP_DIGIT: begin
							wr_data = WORD_W'(cmd.digit);
							if (count_q != FULL_CNT) begin
								wr_en = 1'b1;
								count_d = count_q + CW'(1);
							end else begin
								ovf_d = 1'b1;
							end
						end
						OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
							state_d = ST_POP_A;
							hit_d = (count_q != '0);
							if (count_q != '0) begin
								count_d = top_cnt;
							end else begin
								unf_d = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			ST_POP_A: begin
				a_d = hit_q ? rd_data_q : EMPTY_VALUE;
				hit_d = (count_q != '0);
				if (count_q != '0) begin
					count_d = top_cnt;
				end else begin
					unf_d = 1'b1;
				end
				state_d = ST_POP_B;
			end
			ST_POP_B: begin
				b_d = hit_q ? rd_data_q : EMPTY_VALUE;
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_PUSH;
				case (op_q)
					OP_ADD: res_d = a_q + b_q;
					OP_SUB: res_d = a_q - b_q;
					OP_MUL: res_d = a_q * b_q;
					OP_DIV: begin
						if (b_q == '0) begin
							res_d = '0;
							dz_d = 1'b1;
						end else begin
							div_start = 1'b1;
							state_d = ST_DIV;
						end
					end
					default: res_d = res_q;
				endcase
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					res_d = div_rsp.quotient;
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (count_q != FULL_CNT) begin
					wr_en = 1'b1;
					count_d = count_q + CW'(1);
				end else begin
					ovf_d = 1'b1;
				end
				state_d = final_q ? ST_FIN : ST_IDLE;
			end
			ST_FIN: begin
				hit_d = (count_q != '0);
				if (count_q != '0) begin
					count_d = top_cnt;
				end else begin
					unf_d = 1'b1;
				end
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || !result_stall) begin
					out_valid_d = 1'b1;
					out_d.answer = hit_q ? rd_data_q : EMPTY_VALUE;
					out_d.underflow = unf_q;
					out_d.overflow = ovf_q;
					out_d.divide_by_zero = dz_q;
					count_d = '0;
					unf_d = 1'b0;
					ovf_d = 1'b0;
					dz_d = 1'b0;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			hit_q <= 1'b0;
			unf_q <= 1'b0;
			ovf_q <= 1'b0;
			dz_q <= 1'b0;
			out_valid_q <= 1'b0;
			op_q <= OP_NONE;
			final_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			hit_q <= hit_d;
			unf_q <= unf_d;
			ovf_q <= ovf_d;
			dz_q <= dz_d;
			out_valid_q <= out_valid_d;
			op_q <= op_d;
			final_q <= final_d;
		end
	end

	always_ff @(posedge clk) begin
		a_q <= a_d;
		b_q <= b_d;
		res_q <= res_d;
		out_q <= out_d;
	end

	// top of stack is read every cycle except while the answer waits to emit;
	// write port at the current count
	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[count_q[AW-1:0]] <= wr_data;
		end
		if (state_q != ST_EMIT) begin
			rd_data_q <= stack_mem[top_cnt[AW-1:0]];
		end
	end

endmodule

@@ hdl/prefix_expression_evaluator_top.sv @@
// Evaluates prefix expressions sent one character per transfer, rightmost first,
// and returns one result per expression when the flagged last character arrives.
// Digits are pushed straight from idle in the execution unit; ignored characters
// other than the last are dropped by the front end. + - * go through two stack
// reads, operate and push; / also waits on the 32-step divider unless the divisor
// is zero; the last character adds an answer pop and a result load.
// A four-entry command queue lets the front end keep taking characters meanwhile.
// The operand stack has no reset pass: it is usable right after reset.
// Depends on pexe_pkg, pexe_front, pexe_queue, pexe_exec.
module prefix_expression_evaluator_top #(
	parameter int STACK_DEPTH = pexe_pkg::DEF_STACK_DEPTH,
	parameter int QUEUE_DEPTH = pexe_pkg::DEF_QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  pexe_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output pexe_pkg::result_t result
);
	import pexe_pkg::*;

	logic q_full;
	logic q_push;
	cmd_t q_cmd_in;
	logic q_valid;
	cmd_t q_cmd_out;
	logic q_pop;

	pexe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (q_cmd_in)
	);

	pexe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.cmd_in  (q_cmd_in),
		.full    (q_full),
		.valid   (q_valid),
		.cmd_out (q_cmd_out),
		.pop     (q_pop)
	);

	pexe_exec #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_exec (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_valid),
		.cmd          (q_cmd_out),
		.cmd_pop      (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

@@ hdl/pexe_checker.sv @@
// Port-level checks for prefix_expression_evaluator_top, attached by bind.
// Depends on pexe_pkg.
module pexe_checker #(
	parameter int QUEUE_DEPTH = pexe_pkg::DEF_QUEUE_DEPTH
) (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input pexe_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_stall,
	input pexe_pkg::result_t result
);
	import pexe_pkg::*;

	// front register + queue + command in execution + result register
	localparam int MAX_PENDING = QUEUE_DEPTH + 3;
	localparam int PW = $clog2(MAX_PENDING + 2);

	logic          fin_in;
	logic          res_out;
	logic [PW-1:0] pending_q;

	assign fin_in = item_valid && !item_stall && item.final_req;
	assign res_out = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			case ({fin_in, res_out})
				2'b10:   pending_q <= pending_q + PW'(1);
				2'b01:   pending_q <= pending_q - PW'(1);
				default: pending_q <= pending_q;
			endcase
		end
	end

	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result_valid dropped while stalled");

	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result changed while stalled");

	a_result_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pending_q != '0)
		else $error("result without an outstanding last character");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= PW'(MAX_PENDING))
		else $error("more expressions in flight than buffering allows");

endmodule

bind prefix_expression_evaluator_top pexe_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH)
) u_pexe_checker (.*);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for prefix_expression_evaluator_top: sends prefix expressions
// rightmost character first and checks each result against a local stack evaluator.
// Depends on pexe_pkg and the evaluator RTL.
module tb;
	import pexe_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 60;
	localparam int TOTAL_ITEMS = 900;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	logic [WORD_W-1:0] operand_stack [DEF_STACK_DEPTH];
	int      stack_fill = 0;
	bit      seen_underflow = 1'b0;
	bit      seen_overflow = 1'b0;
	bit      seen_zero_divisor = 1'b0;
	result_t answer_queue [$];
	int      work_items = 0;
	int      error_count = 0;
	int      quiet_cycles = 0;
	bit      no_idle = 1'b0;

	prefix_expression_evaluator_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void push_operand(input logic [WORD_W-1:0] value);
		if (stack_fill >= DEF_STACK_DEPTH) begin
			seen_overflow = 1'b1;
		end else begin
			operand_stack[stack_fill] = value;
			stack_fill++;
		end
	endfunction

	function automatic logic [WORD_W-1:0] pop_operand();
		if (stack_fill == 0) begin
			seen_underflow = 1'b1;
			return EMPTY_VALUE;
		end
		stack_fill--;
		return operand_stack[stack_fill];
	endfunction

	// Applies one accepted character to the local stack; queues the answer on the last one.
	function automatic void evaluate_symbol(input item_t it);
		logic [WORD_W-1:0] a, b, r, mag_a, mag_b;
		result_t res;
		case (it.symbol)
			CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH: begin
				a = pop_operand();
				b = pop_operand();
				case (it.symbol)
					CHAR_PLUS: r = a + b;
					CHAR_MINUS: r = a - b;
					CHAR_STAR: r = a * b;
					default: begin
						if (b == '0) begin
							seen_zero_divisor = 1'b1;
							r = '0;
						end else begin
							mag_a = a[WORD_W-1] ? -a : a;
							mag_b = b[WORD_W-1] ? -b : b;
							r = mag_a / mag_b;
							if (a[WORD_W-1] != b[WORD_W-1])
								r = -r;
						end
					end
				endcase
				push_operand(r);
			end
			default: begin
				if (it.symbol >= CHAR_ZERO && it.symbol <= CHAR_NINE)
					push_operand(WORD_W'(it.symbol - CHAR_ZERO));
			end
		endcase
		if (it.final_req) begin
			res.answer = pop_operand();
			res.underflow = seen_underflow;
			res.overflow = seen_overflow;
			res.divide_by_zero = seen_zero_divisor;
			answer_queue.push_back(res);
			stack_fill = 0;
			seen_underflow = 1'b0;
			seen_overflow = 1'b0;
			seen_zero_divisor = 1'b0;
		end
	endfunction

	task automatic send_item(input logic [7:0] sym, input logic last);
		int gap, r;
		item_t it;
		it.symbol = sym;
		it.final_req = last;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50)
			gap = 0;
		else if (r < 85)
			gap = $urandom_range(1, 3);
		else if (r < 97)
			gap = $urandom_range(4, 10);
		else
			gap = $urandom_range(20, 60);
		if (gap > 0) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		work_items++;
		evaluate_symbol(it);
	endtask

	// Text is written left to right as a prefix expression and sent rightmost first.
	task automatic send_prefix(input string text);
		for (int i = text.len() - 1; i >= 0; i--)
			send_item(text[i], i == 0);
	endtask

	// Well-formed expression with random digits and operators; digit_bias sets how
	// eagerly digits are stacked before operators fold them.
	task automatic send_expression(input int operands, input int digit_bias);
		int digits_left, depth;
		logic [7:0] ch;
		logic last;
		digits_left = operands;
		depth = 0;
		while (digits_left > 0 || depth > 1) begin
			if (depth >= 2 && (digits_left == 0 || $urandom_range(0, 99) >= digit_bias)) begin
				case ($urandom_range(0, 3))
					0: ch = CHAR_PLUS;
					1: ch = CHAR_MINUS;
					2: ch = CHAR_STAR;
					default: ch = CHAR_SLASH;
				endcase
				depth--;
			end else begin
				ch = CHAR_ZERO + 8'($urandom_range(0, 9));
				digits_left--;
				depth++;
			end
			last = (digits_left == 0 && depth == 1);
			if (!last && $urandom_range(0, 9) == 0)
				send_item(8'($urandom_range(8'h3A, 8'hFF)), 1'b0);
			send_item(ch, last);
		end
	endtask

	task automatic send_noise(input int len);
		logic [7:0] ch;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 1))
				ch = 8'($urandom_range(0, 255));
			else
				ch = 8'($urandom_range(CHAR_STAR, CHAR_NINE));
			send_item(ch, i == len - 1);
		end
	endtask

	task automatic test_lone_symbols();
		send_prefix("0");
		send_prefix("9");
		send_item(8'h00, 1'b1);
		send_item(8'hFF, 1'b1);
	endtask

	task automatic test_operators();
		send_prefix("+73");
		send_prefix("-37");
		send_prefix("*73");
		send_prefix("/ -07 2");
	endtask

	task automatic test_sticky_flags();
		send_prefix("/50");
		send_prefix("+");
		send_prefix("12");
	endtask

	// 2 * 8^10 wraps to the most negative value; the divisor comes from an empty pop.
	task automatic test_min_by_minus_one();
		send_prefix("/*8*8*8*8*8*8*8*8*8*82");
	endtask

	task automatic test_stack_overflow();
		no_idle = 1'b1;
		send_expression(DEF_STACK_DEPTH + 1, 100);
		no_idle = 1'b0;
	endtask

	task automatic test_random_mix();
		int r;
		while (work_items < TOTAL_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 72)
				send_expression($urandom_range(1, 10), $urandom_range(30, 90));
			else if (r < 77)
				send_expression($urandom_range(20, 40), 80);
			else
				send_noise($urandom_range(1, 12));
		end
	endtask

	always @(negedge clk) begin : result_stall_gen
		int r;
		static int hold = 0;
		static bit stall_now = 1'b0;
		if (hold == 0) begin
			r = $urandom_range(0, 99);
			stall_now = (r >= 50);
			if (r < 50)
				hold = $urandom_range(1, 30);
			else if (r < 90)
				hold = $urandom_range(1, 3);
			else if (r < 98)
				hold = $urandom_range(4, 12);
			else
				hold = $urandom_range(20, 60);
		end
		hold--;
		result_stall <= stall_now && !no_idle;
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (answer_queue.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %p", $time, result);
				error_count++;
			end else begin
				want = answer_queue.pop_front();
				if (result.answer !== want.answer) begin
					$display("%0t: answer expected %0d actual %0d", $time,
						$signed(want.answer), $signed(result.answer));
					error_count++;
				end
				if (result.underflow !== want.underflow) begin
					$display("%0t: underflow expected %b actual %b", $time,
						want.underflow, result.underflow);
					error_count++;
				end
				if (result.overflow !== want.overflow) begin
					$display("%0t: overflow expected %b actual %b", $time,
						want.overflow, result.overflow);
					error_count++;
				end
				if (result.divide_by_zero !== want.divide_by_zero) begin
					$display("%0t: divide_by_zero expected %b actual %b", $time,
						want.divide_by_zero, result.divide_by_zero);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_lone_symbols();
		test_operators();
		test_sticky_flags();
		test_min_by_minus_one();
		test_stack_overflow();
		test_random_mix();
		@(negedge clk);
		item_valid <= 1'b0;
		while (answer_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

@@ files.f @@
hdl/pexe_pkg.sv
hdl/pexe_front.sv
hdl/pexe_queue.sv
hdl/pexe_div.sv
hdl/pexe_exec.sv
hdl/prefix_expression_evaluator_top.sv
hdl/pexe_checker.sv
tb/sv/tb.sv
